/* rtl/sts_pkg.sv */
// shared types for the stable tagged sorter
package sts_pkg;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic [3:0]         original_position;
        logic               overflowed;
        logic               end_of_run;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

endpackage

/* rtl/sts_store.sv */
// value and position store, one write port and one registered read port
module sts_store import sts_pkg::*; #(
    parameter int MAX_ITEMS = 16,
    parameter int AW = 4
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [31:0] wr_value,
    input  logic [3:0]         wr_pos,
    input  logic [AW-1:0]      rd_addr,
    output logic signed [31:0] rd_value,
    output logic [3:0]         rd_pos
);

    logic [35:0] mem [MAX_ITEMS];
    logic [35:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_value, wr_pos};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_value = rd_reg[35:4];
    assign rd_pos   = rd_reg[3:0];

endmodule

/* rtl/stable_tagged_sorter_unit.sv */
// top level of the stable tagged sorter
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------
//  input   | in_valid  | in_ready  | in_data  (in_beat_t)
//  output  | out_valid | out_ready | out_data (out_beat_t)
//
// loading takes one cycle per beat; value and position go into the store
// memory, and a beat beyond capacity sets the overflow flag instead
// on the last beat the block sorts by selection: for each output rank it scans
// all n entries through the single read port to find the smallest key (value,
// then position) above the previous one, then reads it and emits
// reset clears count, flag and state; store contents need no reset
// the output stage is a register; a stall holds the block in the emit state
module stable_tagged_sorter_unit import sts_pkg::*; #(
    parameter int MAX_ITEMS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    // scan index, rank counter
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] rank_reg, rank_next;
    // previous emitted key, best candidate
    logic [32:0]   prev_key_reg, prev_key_next;
    logic [AW-1:0] prev_addr_reg, prev_addr_next;
    logic          have_prev_reg, have_prev_next;
    logic [32:0]   best_key_reg, best_key_next;
    logic [AW-1:0] best_addr_reg, best_addr_next;
    logic          have_best_reg, have_best_next;
    logic          out_valid_reg, out_valid_next;
    out_beat_t     out_data_reg, out_data_next;

    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_value;
    logic [3:0]         rd_pos;
    logic [AW-1:0]      rd_idx_q;
    logic [32:0]        cand_key;
    logic               cand_above, cand_below;

    sts_store #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[AW-1:0]),
        .wr_value (in_data.value),
        .wr_pos   (4'(count_reg)),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_pos   (rd_pos)
    );

    assign in_ready  = (state_reg == ST_LOAD);
    assign wr_en     = in_valid && in_ready && (count_reg < CW'(MAX_ITEMS));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // unsigned key: sign flipped so order matches signed order, one zero pad
    assign cand_key   = {1'b0, ~rd_value[31], rd_value[30:0]};
    // tie break on store address, which is the arrival order
    assign cand_above = !have_prev_reg || (cand_key > prev_key_reg) ||
                        (cand_key == prev_key_reg && rd_idx_q > prev_addr_reg);
    assign cand_below = !have_best_reg || (cand_key < best_key_reg) ||
                        (cand_key == best_key_reg && rd_idx_q < best_addr_reg);

    // chosen entry stays addressed while the output waits
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        if (state_reg == ST_EMIT_RD || state_reg == ST_EMIT)
        begin
            rd_addr = best_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_q <= rd_addr;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_data.last)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = (rank_reg + 1'b1 == count_reg) ? ST_LOAD : ST_SCAN_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        rank_next      = rank_reg;
        prev_key_next  = prev_key_reg;
        prev_addr_next = prev_addr_reg;
        have_prev_next = have_prev_reg;
        best_key_next  = best_key_reg;
        best_addr_next = best_addr_reg;
        have_best_next = have_best_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    idx_next       = '0;
                    rank_next      = '0;
                    have_prev_next = 1'b0;
                    have_best_next = 1'b0;
                end
            end
            ST_SCAN_RD:
            begin
                idx_next       = idx_reg + 1'b1;
                have_best_next = 1'b0;
            end
            ST_SCAN:
            begin
                if (cand_above && cand_below)
                begin
                    best_key_next  = cand_key;
                    best_addr_next = rd_idx_q;
                    have_best_next = 1'b1;
                end
                if (idx_reg != count_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.sorted_value      = rd_value;
                    out_data_next.original_position = rd_pos;
                    out_data_next.overflowed        = ovf_reg;
                    out_data_next.end_of_run        = (rank_reg + 1'b1 == count_reg);
                    prev_key_next  = best_key_reg;
                    prev_addr_next = best_addr_reg;
                    have_prev_next = 1'b1;
                    rank_next      = rank_reg + 1'b1;
                    idx_next       = '0;
                    if (rank_reg + 1'b1 == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            have_best_reg <= 1'b0;
            idx_reg       <= '0;
            rank_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            have_prev_reg <= have_prev_next;
            have_best_reg <= have_best_next;
            idx_reg       <= idx_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_key_reg  <= prev_key_next;
        prev_addr_reg <= prev_addr_next;
        best_key_reg  <= best_key_next;
        best_addr_reg <= best_addr_next;
        out_data_reg  <= out_data_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("count beyond capacity");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !wr_en)
        else $error("store write while sorting");
    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD) |-> have_best_reg)
        else $error("no candidate found");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_LOAD) |=> (count_reg == '0))
        else $error("count not cleared after burst");

endmodule
